FILE: rtl/weacc_pkg.sv
// ----------------------------------------------------------------------------
// weacc_pkg
// Shared types, widths and constants of the windowed edge weight accumulator.
// ----------------------------------------------------------------------------
package weacc_pkg;

	// default sizing
	localparam int NODES_DEF  = 16;
	localparam int TOPICS_DEF = 4;

	// fixed field widths
	localparam int KIND_W   = 2;
	localparam int TIME_W   = 32;
	localparam int WEIGHT_W = 17;
	localparam int SEL_W    = 2;
	localparam int ACC_W    = 32;
	localparam int UNIT_W   = 20;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 1;

	// window geometry
	localparam int WINDOWS      = 3;
	localparam int RECENT_UNITS = 24;
	localparam int MID_UNITS    = 96;
	localparam int OLD_UNITS    = 384;
	// t + k*unit with t < 2^32 and k*unit < 2^29 fits here
	localparam int CMP_W        = 34;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
	localparam logic [UNIT_W-1:0]   UNIT_RST   = UNIT_W'(1);

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD   = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT   = 1'd1;

	localparam logic [SEL_W-1:0] WIN_RECENT = 2'd0;
	localparam logic [SEL_W-1:0] WIN_MIDDLE = 2'd1;
	localparam logic [SEL_W-1:0] WIN_OLD    = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load_item;   // latch the accepted item
		logic lookup;      // classify, address and read the cell
		logic lookup_read; // lookup belongs to a read item
		logic wr_mod;      // write back the saturated sum
		logic clr_wr;      // zero the cell under the clear pointer
		logic out_load;    // move the read result into the output register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;       // cell exists (in range, window valid)
		logic clr_last;  // clear pointer on the last cell
		logic out_free;  // output register can take a result this cycle
	} dp_status_t;

endpackage

FILE: rtl/weacc_ctrl.sv
// ----------------------------------------------------------------------------
// weacc_ctrl
// Sequencer: clear sweep, item accept, lookup, write-back and result hand-off.
// ----------------------------------------------------------------------------
module weacc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic [weacc_pkg::KIND_W-1:0] s_tuser,
	output logic                   s_tready,
	input  weacc_pkg::dp_status_t  st,
	output weacc_pkg::ctrl_cmd_t   cmd
);
	import weacc_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_MODIFY,
		ST_RESP
	} state_t;

	state_t state_q, state_nx;
	kind_t  kind_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd             = '0;
		state_nx        = state_q;
		cmd.load_item   = accept;
		cmd.lookup_read = (kind_q == KIND_READ);
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (kind_t'(s_tuser))
						KIND_ADD, KIND_READ: state_nx = ST_LOOKUP;
						KIND_CLEAR:          state_nx = ST_CLEAR;
						KIND_NOP:            state_nx = ST_IDLE;
						default:             state_nx = ST_IDLE;
					endcase
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (kind_q == KIND_READ) begin
					state_nx = ST_RESP;
				end else if (st.hit) begin
					state_nx = ST_MODIFY;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			ST_MODIFY: begin
				cmd.wr_mod = 1'b1;
				state_nx   = ST_IDLE;
			end
			ST_RESP: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			kind_q  <= KIND_NOP;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				kind_q <= kind_t'(s_tuser);
			end
		end
	end

endmodule

FILE: rtl/weacc_dp.sv
// ----------------------------------------------------------------------------
// weacc_dp
// Datapath: config registers, item registers, window classifier, weight
// store with registered read, saturating adder and output register.
// ----------------------------------------------------------------------------
module weacc_dp #(
	parameter int NODES  = weacc_pkg::NODES_DEF,
	parameter int TOPICS = weacc_pkg::TOPICS_DEF,
	parameter int NODE_W = $clog2(NODES),
	parameter int TOPIC_W = (TOPICS > 1) ? $clog2(TOPICS) : 1,
	parameter int IN_W   = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [weacc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [weacc_pkg::CFG_W-1:0]     cfg_data,
	input  logic [IN_W-1:0]                 s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [weacc_pkg::ACC_W-1:0]     m_tdata,
	output logic                            m_tuser,
	input  weacc_pkg::ctrl_cmd_t            cmd,
	output weacc_pkg::dp_status_t           st
);
	import weacc_pkg::*;

	localparam int CELL_W = TOPIC_W + 2 * NODE_W;
	localparam int DEPTH  = WINDOWS * (2 ** CELL_W);
	localparam int AW     = CELL_W + SEL_W;

	// tdata field offsets
	localparam int TO_LSB  = NODE_W;
	localparam int T_LSB   = 2 * NODE_W;
	localparam int TP_LSB  = T_LSB + TIME_W;
	localparam int W_LSB   = TP_LSB + TOPIC_W;
	localparam int SEL_LSB = W_LSB + WEIGHT_W;

	localparam logic [NODE_W:0]  NODES_L  = (NODE_W + 1)'(NODES);
	localparam logic [TOPIC_W:0] TOPICS_L = (TOPIC_W + 1)'(TOPICS);
	localparam logic [AW-1:0]    LAST_A   = AW'(DEPTH - 1);

	// configuration
	logic [TIME_W-1:0] cutoff_q;
	logic [UNIT_W-1:0] unit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= '0;
			unit_q   <= UNIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CUTOFF: cutoff_q <= cfg_data;
				CFG_UNIT:   unit_q   <= cfg_data[UNIT_W-1:0];
				default: ;
			endcase
		end
	end

	// item registers
	logic [NODE_W-1:0]   from_q, to_q;
	logic [TIME_W-1:0]   time_q;
	logic [TOPIC_W-1:0]  topic_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [SEL_W-1:0]    sel_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			from_q   <= s_tdata[TO_LSB-1:0];
			to_q     <= s_tdata[T_LSB-1:TO_LSB];
			time_q   <= s_tdata[TP_LSB-1:T_LSB];
			topic_q  <= s_tdata[W_LSB-1:TP_LSB];
			weight_q <= s_tdata[SEL_LSB-1:W_LSB];
			sel_q    <= s_tdata[SEL_LSB+SEL_W-1:SEL_LSB];
		end
	end

	// window classification: t >= cutoff - k*unit  <=>  t + k*unit >= cutoff
	logic [CMP_W-1:0] u_x, t_x, c_x, b_recent, b_mid, b_old;
	logic             in_recent, in_mid, in_old, in_range, hit;
	logic [SEL_W-1:0] win;
	logic [AW-1:0]    addr;

	always_comb begin
		u_x      = CMP_W'(unit_q);
		t_x      = CMP_W'(time_q);
		c_x      = CMP_W'(cutoff_q);
		b_recent = (u_x << 4) + (u_x << 3);   // 24
		b_mid    = (u_x << 6) + (u_x << 5);   // 96
		b_old    = (u_x << 8) + (u_x << 7);   // 384
		in_recent = (t_x + b_recent) >= c_x;
		in_mid    = (t_x + b_mid) >= c_x;
		in_old    = (t_x + b_old) >= c_x;
		in_range  = ({1'b0, from_q} < NODES_L) && ({1'b0, to_q} < NODES_L)
			&& ({1'b0, topic_q} < TOPICS_L);
		if (cmd.lookup_read) begin
			win = sel_q;
			hit = in_range && (sel_q <= WIN_OLD);
		end else begin
			win = in_recent ? WIN_RECENT : (in_mid ? WIN_MIDDLE : WIN_OLD);
			hit = in_range && in_old;
		end
		addr = {win, topic_q, from_q, to_q};
	end

	// clear pointer
	logic [AW-1:0] clr_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_ptr_q <= (clr_ptr_q == LAST_A) ? '0 : clr_ptr_q + 1'b1;
		end
	end

	// lookup results
	logic [AW-1:0] addr_q;
	logic          hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.lookup) begin
			hit_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			addr_q <= addr;
		end
	end

	// weight store
	logic [ACC_W-1:0] mem [DEPTH];
	logic [ACC_W-1:0] rd_q;
	logic [ACC_W-1:0] wr_data;
	logic [AW-1:0]    wr_addr;
	logic [WEIGHT_W-1:0] w_sat;
	logic [ACC_W:0]   sum;

	always_comb begin
		w_sat   = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
		sum     = {1'b0, rd_q} + (ACC_W + 1)'(w_sat);
		wr_addr = cmd.clr_wr ? clr_ptr_q : addr_q;
		wr_data = cmd.clr_wr ? '0 : (sum[ACC_W] ? '1 : sum[ACC_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr || cmd.wr_mod) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.lookup) begin
			rd_q <= mem[addr];
		end
	end

	// output register
	logic             out_valid_q;
	logic [ACC_W-1:0] out_data_q;
	logic [ACC_W-1:0] cell_val;

	assign cell_val = hit_q ? rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= cell_val;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = &out_data_q;

	assign st.hit      = hit;
	assign st.clr_last = (clr_ptr_q == LAST_A);
	assign st.out_free = !out_valid_q || m_tready;

endmodule

FILE: rtl/windowed_edge_weight_accumulator_unit.sv
// ----------------------------------------------------------------------------
// windowed_edge_weight_accumulator_unit
// Top level: per-topic recent/middle/old sender x receiver weight matrices.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An add is latched on acceptance, then
// looked up with a memory read, then its saturated sum is written back;
// nothing is written back when the edge is too old or out of range. A
// read is latched, looked up and then waits for the output register to
// drain; kind 3 is a no-op. A clear, and the sweep right after reset,
// write one cell per cycle through the single write port of the weight
// store, so s_tready stays low until all 3 * 2^(TOPIC_W + 2*NODE_W) cells
// (3072 at the default sizing) are zeroed. Config writes go straight
// into the cutoff and time-unit registers and are taken at any time.
// Window edges sit 24, 96 and 384 time units before the cutoff; the
// comparison is exact and never wraps, so a zero time unit makes every edge
// before the cutoff too old. Weights above one (65536) are clamped and a
// cell sticks at 0xFFFFFFFF; m_tuser flags that value on reads.
// ----------------------------------------------------------------------------
module windowed_edge_weight_accumulator_unit #(
	parameter int NODES  = weacc_pkg::NODES_DEF,
	parameter int TOPICS = weacc_pkg::TOPICS_DEF,
	parameter int NODE_W  = $clog2(NODES),
	parameter int TOPIC_W = (TOPICS > 1) ? $clog2(TOPICS) : 1,
	parameter int IN_W = ((2 * NODE_W + weacc_pkg::TIME_W + TOPIC_W
		+ weacc_pkg::WEIGHT_W + weacc_pkg::SEL_W + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [weacc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [weacc_pkg::CFG_W-1:0]     cfg_data,
	// item input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// from_node, to_node, event_time, topic, weight, window_select, zero pad
	input  logic [IN_W-1:0]                 s_tdata,
	// kind
	input  logic [weacc_pkg::KIND_W-1:0]    s_tuser,
	// read result
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cell_value
	output logic [weacc_pkg::ACC_W-1:0]     m_tdata,
	// cell_saturated
	output logic                            m_tuser
);
	import weacc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t st;

	weacc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	weacc_dp #(
		.NODES   (NODES),
		.TOPICS  (TOPICS),
		.NODE_W  (NODE_W),
		.TOPIC_W (TOPIC_W),
		.IN_W    (IN_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

FILE: rtl/weacc_checker.sv
// ----------------------------------------------------------------------------
// weacc_checker
// Port-level checks of the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module weacc_checker #(
	parameter int IN_W = 64
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [IN_W-1:0]                 s_tdata,
	input logic [weacc_pkg::KIND_W-1:0]    s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [weacc_pkg::ACC_W-1:0]     m_tdata,
	input logic                            m_tuser
);
	import weacc_pkg::*;

	// one item at a time: anything but a no-op keeps the input closed next cycle
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != KIND_NOP) |=> !s_tready)
		else $error("input reopened right after an item");

	// saturation flag matches the value
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (&m_tdata)))
		else $error("cell_saturated disagrees with cell_value");

	// a result appears only after a busy cycle (the read's response), never from idle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result produced while input side idle");

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind windowed_edge_weight_accumulator_unit weacc_checker #(.IN_W(IN_W)) u_weacc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
